// ----- rtl/rtmcs_pkg.sv -----
`timescale 1ns / 1ps

package rtmcs_pkg;

  localparam int unsigned POOL_SIZE = 64;
  localparam int unsigned IDX_W     = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W     = $clog2(POOL_SIZE + 1);

  localparam int unsigned DAY_W  = 21;
  localparam int unsigned COST_W = 32;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned PEN_W  = 33;

  localparam logic [DAY_W-1:0] DAY_LIMIT = 21'd2097151;

  // item kind
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ADDED  = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_SERVED = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [DAY_W-1:0]  release_day;
    logic [COST_W-1:0] job_cost;
    logic [TAG_W-1:0]  job_tag;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TAG_W-1:0]  served_tag;
    logic [DAY_W-1:0]  served_day;
    logic [PEN_W-1:0]  job_penalty;
    logic [PEN_W-1:0]  peak_penalty;
    logic              pool_empty;
  } out_t;

  // one pool entry as kept in the memory
  typedef struct packed {
    logic [DAY_W-1:0]  release_day;
    logic [COST_W-1:0] job_cost;
    logic [TAG_W-1:0]  job_tag;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted item, clear scan state
    logic add_step;  // advance free-slot search
    logic scan_rd;   // read one entry for the best-job scan
    logic commit;    // apply the item and load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic pool_full;
    logic day_over;
    logic slot_free;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/rtmcs_ctrl.sv -----
`timescale 1ns / 1ps

module rtmcs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rtmcs_pkg::stat_t stat_i,
  output rtmcs_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_ADD_SCAN = 3'd2;
  localparam logic [2:0] S_TICK_SCAN = 3'd3;
  localparam logic [2:0] S_TICK_LAST = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.is_tick && !stat_i.day_over) begin
          state_d = S_TICK_SCAN;
        end else if (!stat_i.is_tick && !stat_i.pool_full) begin
          state_d = S_ADD_SCAN;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_ADD_SCAN: begin
        if (stat_i.slot_free) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.add_step = 1'b1;
        end
      end
      S_TICK_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_TICK_LAST;
        end
      end
      S_TICK_LAST: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/rtmcs_dpath.sv -----
`timescale 1ns / 1ps

module rtmcs_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rtmcs_pkg::in_t   in_data_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output rtmcs_pkg::out_t  out_data_o,
  input  rtmcs_pkg::cmd_t  cmd_i,
  output rtmcs_pkg::stat_t stat_o
);

  rtmcs_pkg::entry_t mem [rtmcs_pkg::POOL_SIZE];

  rtmcs_pkg::in_t                  item_q;
  logic [rtmcs_pkg::POOL_SIZE-1:0] valid_q;
  logic [rtmcs_pkg::IDX_W-1:0]     k_q;
  logic [rtmcs_pkg::CNT_W-1:0]     count_q, count_d;
  logic [rtmcs_pkg::DAY_W-1:0]     day_q;
  logic [rtmcs_pkg::PEN_W-1:0]     peak_q, peak_d;

  rtmcs_pkg::entry_t           rd_q;
  logic                        rd_live_q;
  logic                        rd_ok_q;
  logic [rtmcs_pkg::IDX_W-1:0] rd_idx_q;

  rtmcs_pkg::entry_t           best_q;
  logic [rtmcs_pkg::IDX_W-1:0] best_idx_q;
  logic                        found_q;

  rtmcs_pkg::out_t out_q, out_d;
  logic            out_valid_q;

  logic                        is_tick;
  logic                        pool_full;
  logic                        day_over;
  logic                        beats;
  logic                        take;
  logic [rtmcs_pkg::DAY_W-1:0] wait_days;
  logic [rtmcs_pkg::PEN_W-1:0] pen;

  assign is_tick   = (item_q.mode == rtmcs_pkg::MODE_TICK);
  assign pool_full = (count_q == rtmcs_pkg::CNT_W'(rtmcs_pkg::POOL_SIZE));
  assign day_over  = (day_q >= rtmcs_pkg::DAY_LIMIT);

  assign stat_o.is_tick   = is_tick;
  assign stat_o.pool_full = pool_full;
  assign stat_o.day_over  = day_over;
  assign stat_o.slot_free = !valid_q[k_q];
  assign stat_o.scan_last = (k_q == rtmcs_pkg::IDX_W'(rtmcs_pkg::POOL_SIZE - 1));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // candidate beats best: cost, then later release, then larger tag
  always_comb begin
    if (rd_q.job_cost != best_q.job_cost) begin
      beats = (rd_q.job_cost > best_q.job_cost);
    end else if (rd_q.release_day != best_q.release_day) begin
      beats = (rd_q.release_day > best_q.release_day);
    end else begin
      beats = (rd_q.job_tag > best_q.job_tag);
    end
  end

  assign take = rd_live_q && rd_ok_q && (rd_q.release_day <= day_q) && (!found_q || beats);

  assign wait_days = day_q - best_q.release_day;
  assign pen = {1'b0, best_q.job_cost} + {{(rtmcs_pkg::PEN_W - rtmcs_pkg::DAY_W){1'b0}}, wait_days};

  // result and bookkeeping for the commit cycle
  always_comb begin
    out_d   = '0;
    count_d = count_q;
    peak_d  = peak_q;
    if (!is_tick) begin
      if (pool_full) begin
        out_d.status = rtmcs_pkg::ST_FULL;
      end else begin
        out_d.status = rtmcs_pkg::ST_ADDED;
        count_d      = count_q + rtmcs_pkg::CNT_W'(1);
      end
    end else if (!day_over && found_q) begin
      out_d.status      = rtmcs_pkg::ST_SERVED;
      out_d.served_tag  = best_q.job_tag;
      out_d.served_day  = day_q;
      out_d.job_penalty = pen;
      count_d           = count_q - rtmcs_pkg::CNT_W'(1);
      if (pen > peak_q) begin
        peak_d = pen;
      end
    end else begin
      out_d.status = rtmcs_pkg::ST_IDLE;
    end
    out_d.peak_penalty = peak_d;
    out_d.pool_empty   = (count_d == '0);
  end

  // pool memory, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !is_tick && !pool_full) begin
      mem[k_q] <= '{release_day: item_q.release_day,
                    job_cost:    item_q.job_cost,
                    job_tag:     item_q.job_tag};
    end
    if (cmd_i.scan_rd) begin
      rd_q <= mem[k_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.scan_rd) begin
      rd_idx_q <= k_q;
    end
    if (take) begin
      best_q     <= rd_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      k_q         <= '0;
      count_q     <= '0;
      day_q       <= '0;
      peak_q      <= '0;
      rd_live_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_live_q <= cmd_i.scan_rd;
      if (cmd_i.scan_rd) begin
        rd_ok_q <= valid_q[k_q];
      end
      if (cmd_i.load) begin
        k_q     <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.add_step || cmd_i.scan_rd) begin
        k_q <= k_q + rtmcs_pkg::IDX_W'(1);
      end
      if (take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        count_q <= count_d;
        peak_q  <= peak_d;
        if (!is_tick) begin
          if (!pool_full) begin
            valid_q[k_q] <= 1'b1;
          end
        end else if (!day_over) begin
          day_q <= day_q + rtmcs_pkg::DAY_W'(1);
          if (found_q) begin
            valid_q[best_idx_q] <= 1'b0;
          end
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/release_time_max_cost_scheduler.sv -----
`timescale 1ns / 1ps

// channel  | signals                          | direction | transfer when
// ---------+----------------------------------+-----------+---------------------------
// in       | in_valid_i, in_stall_o, in_data_i    | to block  | in_valid_i && !in_stall_o
// out      | out_valid_o, out_stall_i, out_data_o | from block| out_valid_o && !out_stall_i
//
// one item at a time: an add searches for the lowest free slot, skipping the search
// when the pool is full; a tick before the day limit scans every pool slot through
// the single read port of the pool memory, one slot per cycle
// reset clears the valid bits, the day and the peak penalty; no clearing pass is needed
// a stalled output holds the finished result; the block still takes a new item and only
// waits at its commit step until the output register is free

module release_time_max_cost_scheduler (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rtmcs_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rtmcs_pkg::out_t out_data_o
);

  // command and status between sequencer and datapath
  rtmcs_pkg::cmd_t  cmd;
  rtmcs_pkg::stat_t stat;

  // sequencer: dispatch, free-slot search, best-job scan, commit
  rtmcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: pool memory, valid bits, day, peak penalty, output register
  rtmcs_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
